>>> rtl/msp_pkg.sv
// Shared types and constants for the manifest stream parser.
// Holds the one-hot phase encoding, field kind and status codes, and the result record.
// No dependencies.
package msp_pkg;

    typedef enum logic [11:0] {
        PH_MAGIC  = 12'b0000_0000_0001,
        PH_BLEN   = 12'b0000_0000_0010,
        PH_COUNT  = 12'b0000_0000_0100,
        PH_PLEN   = 12'b0000_0000_1000,
        PH_PATH   = 12'b0000_0001_0000,
        PH_OFFSET = 12'b0000_0010_0000,
        PH_SIZE   = 12'b0000_0100_0000,
        PH_FHASH  = 12'b0000_1000_0000,
        PH_FMT    = 12'b0001_0000_0000,
        PH_SLACK  = 12'b0010_0000_0000,
        PH_MHASH  = 12'b0100_0000_0000,
        PH_BEYOND = 12'b1000_0000_0000
    } phase_t;

    localparam logic [3:0] KIND_MAGIC  = 4'd0;
    localparam logic [3:0] KIND_BLEN   = 4'd1;
    localparam logic [3:0] KIND_COUNT  = 4'd2;
    localparam logic [3:0] KIND_PLEN   = 4'd3;
    localparam logic [3:0] KIND_PATH   = 4'd4;
    localparam logic [3:0] KIND_OFFSET = 4'd5;
    localparam logic [3:0] KIND_SIZE   = 4'd6;
    localparam logic [3:0] KIND_FHASH  = 4'd7;
    localparam logic [3:0] KIND_FMT    = 4'd8;
    localparam logic [3:0] KIND_SLACK  = 4'd9;
    localparam logic [3:0] KIND_MHASH  = 4'd10;
    localparam logic [3:0] KIND_BEYOND = 4'd11;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BODY_LEN  = 3'd2;
    localparam logic [2:0] ST_COUNT     = 3'd3;
    localparam logic [2:0] ST_PATH_LEN  = 3'd4;
    localparam logic [2:0] ST_OVERRUN   = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    localparam logic [2:0] CFG_MIN_BODY_LEN   = 3'd0;
    localparam logic [2:0] CFG_MAX_BODY_LEN   = 3'd1;
    localparam logic [2:0] CFG_MAX_FILE_COUNT = 3'd2;
    localparam logic [2:0] CFG_MIN_PATH_LEN   = 3'd3;
    localparam logic [2:0] CFG_MAX_PATH_LEN   = 3'd4;

    localparam logic [31:0] MIN_BODY_FLOOR = 32'd4;
    localparam logic [34:0] HEADER_BYTES   = 35'd8;
    localparam logic [34:0] FIRST_PLEN_END = 35'd14;
    localparam logic [34:0] FIXED_TAIL     = 35'd50;
    localparam logic [15:0] HASH_LAST_IDX  = 16'd31;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [15:0] byte_in_field;
        logic [31:0] entry_number;
        logic [7:0]  byte_echo;
        logic [63:0] field_value;
        logic        field_complete;
        logic [2:0]  status;
        logic        finished;
    } msp_result_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h4D;
            2'd1: b = 8'h46;
            2'd2: b = 8'h53;
            2'd3: b = 8'h54;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] phase_kind(input phase_t ph);
        logic [3:0] k;
        unique case (ph)
            PH_MAGIC:  k = KIND_MAGIC;
            PH_BLEN:   k = KIND_BLEN;
            PH_COUNT:  k = KIND_COUNT;
            PH_PLEN:   k = KIND_PLEN;
            PH_PATH:   k = KIND_PATH;
            PH_OFFSET: k = KIND_OFFSET;
            PH_SIZE:   k = KIND_SIZE;
            PH_FHASH:  k = KIND_FHASH;
            PH_FMT:    k = KIND_FMT;
            PH_SLACK:  k = KIND_SLACK;
            PH_MHASH:  k = KIND_MHASH;
            default:   k = KIND_BEYOND;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/manifest_stream_parser_core.sv
// Top level of the manifest stream parser: byte parsing, field tagging and output buffering.
// Depends on msp_pkg for the phase encoding, codes and result record.
//
// Usage: manifest bytes enter on the input channel (in_valid, in_stall, data_byte, last),
// one byte per transfer, with last set on the final byte of the buffer. Each byte gives
// exactly one result on the output channel (out_valid, out_stall and the field ports),
// which tags the byte with its field, its position and entry, and the value assembled so far.
// Results are registered, and the block sustains one byte per cycle while in_stall is low;
// the parse state and its compares update per byte. When the receiver stalls, the output
// register holds its result and one further result is caught in a skid register; in_stall
// rises only while that skid register is occupied, so no result is lost and none is repeated.
// The configuration registers are written through cfg_wr_en, cfg_index and cfg_wr_data; the
// user must write them only while the block is idle (not enforced); an unknown index is
// ignored. Reset returns the parser to the magic field with no error and the configuration
// registers to their defaults. After the trailing hash, an error or truncation, every later
// byte is reported as beyond the manifest with the sticky status until the next reset.
module manifest_stream_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  field_kind,
    output logic [15:0] byte_in_field,
    output logic [31:0] entry_number,
    output logic [7:0]  byte_echo,
    output logic [63:0] field_value,
    output logic        field_complete,
    output logic [2:0]  status,
    output logic        finished,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);
    import msp_pkg::*;

    logic [31:0] min_body_len_reg;
    logic [31:0] max_body_len_reg;
    logic [31:0] max_file_count_reg;
    logic [15:0] min_path_len_reg;
    logic [15:0] max_path_len_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] fcount_reg, fcount_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] body_len_reg, body_len_next;
    logic [31:0] file_count_reg, file_count_next;
    logic [31:0] entry_reg, entry_next;
    logic [33:0] pos_reg, pos_next;
    logic [15:0] path_len_reg, path_len_next;
    logic [2:0]  err_reg, err_next;

    msp_result_t out_reg, skid_reg, res;
    logic        out_valid_reg, skid_valid_reg;
    logic        in_fire, out_free;

    logic [63:0] acc_upd;
    logic        numeric;
    logic [34:0] end_pos, pos1;
    logic [31:0] ent_inc;
    phase_t      next_ph;
    logic        done, fin;
    logic [2:0]  err;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign acc_upd = acc_reg | (64'(data_byte) << {fcount_reg[2:0], 3'b000});
    assign end_pos = {3'b000, body_len_reg} + HEADER_BYTES;
    assign pos1    = {1'b0, pos_reg} + 35'd1;
    assign ent_inc = entry_reg + 32'd1;
    assign numeric = (phase_reg == PH_MAGIC) || (phase_reg == PH_BLEN) ||
                     (phase_reg == PH_COUNT) || (phase_reg == PH_PLEN) ||
                     (phase_reg == PH_OFFSET) || (phase_reg == PH_SIZE) ||
                     (phase_reg == PH_FMT);

    always_comb
    begin
        next_ph         = phase_reg;
        done            = 1'b0;
        fin             = 1'b0;
        err             = ST_OK;
        body_len_next   = body_len_reg;
        file_count_next = file_count_reg;
        entry_next      = entry_reg;
        path_len_next   = path_len_reg;

        res.field_kind     = phase_kind(phase_reg);
        res.byte_in_field  = fcount_reg;
        res.entry_number   = 32'd0;
        res.byte_echo      = data_byte;
        res.field_value    = numeric ? acc_upd : {56'd0, data_byte};
        res.field_complete = 1'b0;
        res.status         = ST_OK;
        res.finished       = 1'b0;

        unique case (phase_reg)
            PH_MAGIC:
            begin
                if (data_byte != magic_byte(fcount_reg[1:0]))
                begin
                    err = ST_BAD_MAGIC;
                end
                if (fcount_reg >= 16'd3)
                begin
                    done    = 1'b1;
                    next_ph = PH_BLEN;
                end
            end
            PH_BLEN:
            begin
                if (fcount_reg >= 16'd3)
                begin
                    done          = 1'b1;
                    body_len_next = acc_upd[31:0];
                    if (acc_upd[31:0] < MIN_BODY_FLOOR || acc_upd[31:0] < min_body_len_reg ||
                        acc_upd[31:0] > max_body_len_reg)
                    begin
                        err = ST_BODY_LEN;
                    end
                    else
                    begin
                        next_ph = PH_COUNT;
                    end
                end
            end
            PH_COUNT:
            begin
                if (fcount_reg >= 16'd3)
                begin
                    done            = 1'b1;
                    file_count_next = acc_upd[31:0];
                    entry_next      = 32'd0;
                    if (acc_upd[31:0] == 32'd0 || acc_upd[31:0] > max_file_count_reg)
                    begin
                        err = ST_COUNT;
                    end
                    else if (FIRST_PLEN_END > end_pos)
                    begin
                        err = ST_OVERRUN;
                    end
                    else
                    begin
                        next_ph = PH_PLEN;
                    end
                end
            end
            PH_PLEN:
            begin
                res.entry_number = entry_reg;
                if (fcount_reg >= 16'd1)
                begin
                    done          = 1'b1;
                    path_len_next = acc_upd[15:0];
                    if (acc_upd[15:0] < min_path_len_reg || acc_upd[15:0] > max_path_len_reg)
                    begin
                        err = ST_PATH_LEN;
                    end
                    else if (pos1 + {19'd0, acc_upd[15:0]} + FIXED_TAIL > end_pos)
                    begin
                        err = ST_OVERRUN;
                    end
                    else
                    begin
                        next_ph = (acc_upd[15:0] == 16'd0) ? PH_OFFSET : PH_PATH;
                    end
                end
            end
            PH_PATH:
            begin
                res.entry_number = entry_reg;
                if ({1'b0, fcount_reg} + 17'd1 >= {1'b0, path_len_reg})
                begin
                    done    = 1'b1;
                    next_ph = PH_OFFSET;
                end
            end
            PH_OFFSET:
            begin
                res.entry_number = entry_reg;
                if (fcount_reg >= 16'd7)
                begin
                    done    = 1'b1;
                    next_ph = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                res.entry_number = entry_reg;
                if (fcount_reg >= 16'd7)
                begin
                    done    = 1'b1;
                    next_ph = PH_FHASH;
                end
            end
            PH_FHASH:
            begin
                res.entry_number = entry_reg;
                if (fcount_reg >= HASH_LAST_IDX)
                begin
                    done    = 1'b1;
                    next_ph = PH_FMT;
                end
            end
            PH_FMT:
            begin
                res.entry_number = entry_reg;
                if (fcount_reg >= 16'd1)
                begin
                    done       = 1'b1;
                    entry_next = ent_inc;
                    if (ent_inc == file_count_reg)
                    begin
                        next_ph = (pos1 < end_pos) ? PH_SLACK : PH_MHASH;
                    end
                    else if (pos1 + 35'd2 > end_pos)
                    begin
                        err = ST_OVERRUN;
                    end
                    else
                    begin
                        next_ph = PH_PLEN;
                    end
                end
            end
            PH_SLACK:
            begin
                if (pos1 >= end_pos)
                begin
                    done    = 1'b1;
                    next_ph = PH_MHASH;
                end
            end
            PH_MHASH:
            begin
                if (fcount_reg >= HASH_LAST_IDX)
                begin
                    done    = 1'b1;
                    fin     = 1'b1;
                    next_ph = PH_BEYOND;
                end
            end
            default:
            begin
                res.field_kind    = KIND_BEYOND;
                res.byte_in_field = 16'd0;
                res.field_value   = 64'd0;
                res.status        = err_reg;
                res.finished      = 1'b1;
            end
        endcase

        fcount_next = done ? 16'd0 : fcount_reg + 16'd1;
        acc_next    = done ? 64'd0 : (numeric ? acc_upd : acc_reg);
        pos_next    = pos_reg + 34'd1;
        err_next    = err_reg;
        phase_next  = next_ph;

        if (phase_reg != PH_BEYOND)
        begin
            res.field_complete = done;
            res.finished       = fin;
            if (err != ST_OK)
            begin
                err_next     = err;
                res.status   = err;
                res.finished = 1'b1;
                phase_next   = PH_BEYOND;
            end
            else if (last && next_ph != PH_BEYOND)
            begin
                err_next     = ST_TRUNCATED;
                res.status   = ST_TRUNCATED;
                res.finished = 1'b1;
                phase_next   = PH_BEYOND;
            end
        end
        else
        begin
            phase_next      = PH_BEYOND;
            fcount_next     = fcount_reg;
            acc_next        = acc_reg;
            pos_next        = pos_reg;
            body_len_next   = body_len_reg;
            file_count_next = file_count_reg;
            entry_next      = entry_reg;
            path_len_next   = path_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_body_len_reg   <= 32'd4;
            max_body_len_reg   <= 32'd16777216;
            max_file_count_reg <= 32'd65536;
            min_path_len_reg   <= 16'd1;
            max_path_len_reg   <= 16'd4096;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MIN_BODY_LEN:   min_body_len_reg   <= cfg_wr_data;
                CFG_MAX_BODY_LEN:   max_body_len_reg   <= cfg_wr_data;
                CFG_MAX_FILE_COUNT: max_file_count_reg <= cfg_wr_data;
                CFG_MIN_PATH_LEN:   min_path_len_reg   <= cfg_wr_data[15:0];
                CFG_MAX_PATH_LEN:   max_path_len_reg   <= cfg_wr_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC;
            fcount_reg     <= 16'd0;
            acc_reg        <= 64'd0;
            body_len_reg   <= 32'd0;
            file_count_reg <= 32'd0;
            entry_reg      <= 32'd0;
            pos_reg        <= 34'd0;
            path_len_reg   <= 16'd0;
            err_reg        <= ST_OK;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            fcount_reg     <= fcount_next;
            acc_reg        <= acc_next;
            body_len_reg   <= body_len_next;
            file_count_reg <= file_count_next;
            entry_reg      <= entry_next;
            pos_reg        <= pos_next;
            path_len_reg   <= path_len_next;
            err_reg        <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_free)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_free)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign field_kind     = out_reg.field_kind;
    assign byte_in_field  = out_reg.byte_in_field;
    assign entry_number   = out_reg.entry_number;
    assign byte_echo      = out_reg.byte_echo;
    assign field_value    = out_reg.field_value;
    assign field_complete = out_reg.field_complete;
    assign status         = out_reg.status;
    assign finished       = out_reg.finished;

    // The skid register is only ever filled behind a waiting output result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    // Once parsing has stopped it never resumes before reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BEYOND) |=> (phase_reg == PH_BEYOND))
        else $error("parser left the stopped phase");

    // A recorded error is sticky.
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK) |=> $stable(err_reg))
        else $error("sticky error code changed");

    // An error can only be recorded on the way into the stopped phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK) |-> (phase_reg == PH_BEYOND))
        else $error("error recorded while parsing continues");

endmodule

>>> sim/manifest_stream_parser_core_tb.sv
// Self-checking testbench for manifest_stream_parser_core: streams one long manifest with
// random content, random idling and register changes between entry groups, checking each tag.
// Depends on msp_pkg and the RTL of manifest_stream_parser_core; needs no other file.
module manifest_stream_parser_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import msp_pkg::*;

    localparam int          HALF_PERIOD    = 5;
    localparam int          RESET_CYCLES   = 11;
    localparam int          MAX_GAP        = 17;
    localparam int unsigned LONG_HOLD_AT   = 150;
    localparam int unsigned LONG_HOLD      = 120;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 50;
    localparam logic [31:0] MAGIC_LE       = 32'h5453_464D;
    localparam int unsigned ENTRY_FIXED    = 52;
    localparam int unsigned HASH_LEN       = 32;
    localparam int unsigned NOISE_BYTES    = 40;

    typedef enum {
        END_COMPLETE,
        END_TRUNCATED,
        END_PATH_RANGE,
        END_OVERRUN
    } ending_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } manifest_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  field_kind;
    logic [15:0] byte_in_field;
    logic [31:0] entry_number;
    logic [7:0]  byte_echo;
    logic [63:0] field_value;
    logic        field_complete;
    logic [2:0]  status;
    logic        finished;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_wr_data = 32'd0;

    // Parser state as predicted.
    logic [3:0]  cur_field = KIND_MAGIC;
    logic [15:0] fld_idx = 16'd0;
    logic [63:0] value_acc = 64'd0;
    logic [31:0] body_len = 32'd0;
    logic [31:0] n_files = 32'd0;
    logic [31:0] entry_idx = 32'd0;
    logic [33:0] stream_pos = 34'd0;
    logic [15:0] path_len = 16'd0;
    logic [2:0]  sticky_status = ST_OK;

    // Register values as written.
    logic [31:0] lim_min_body = 32'd4;
    logic [31:0] lim_max_body = 32'd16777216;
    logic [31:0] lim_max_files = 32'd65536;
    logic [15:0] lim_min_path = 16'd1;
    logic [15:0] lim_max_path = 16'd4096;

    manifest_byte_t manifest_bytes_pending[$];
    msp_result_t    tags_due[$];
    msp_result_t    tag_want;
    manifest_byte_t next_item;

    int unsigned path_plan[28];
    logic [15:0] plen_field[28];
    logic [15:0] min_p[4];
    logic [15:0] max_p[4];
    longint      gen_pos = 0;
    longint      cut_at = -1;

    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    manifest_stream_parser_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .field_kind     (field_kind),
        .byte_in_field  (byte_in_field),
        .entry_number   (entry_number),
        .byte_echo      (byte_echo),
        .field_value    (field_value),
        .field_complete (field_complete),
        .status         (status),
        .finished       (finished),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic msp_result_t tag_manifest_byte(input logic [7:0] b, input logic lst);
        msp_result_t r;
        logic [15:0] idx;
        logic [3:0]  nxt;
        logic [2:0]  err;
        logic        done;
        logic        fin;
        logic [35:0] pos;
        logic [35:0] stop;
        r = '0;
        r.byte_echo = b;
        if (cur_field == KIND_BEYOND)
        begin
            r.field_kind = KIND_BEYOND;
            r.status = sticky_status;
            r.finished = 1'b1;
            return r;
        end
        idx = fld_idx;
        nxt = cur_field;
        err = ST_OK;
        done = 1'b0;
        fin = 1'b0;
        pos = {2'd0, stream_pos};
        stop = 36'd8 + {4'd0, body_len};
        r.field_kind = cur_field;
        r.byte_in_field = idx;
        if (cur_field inside {KIND_MAGIC, KIND_BLEN, KIND_COUNT, KIND_PLEN, KIND_OFFSET,
                              KIND_SIZE, KIND_FMT})
        begin
            value_acc = value_acc | ({56'd0, b} << {idx[2:0], 3'b000});
            r.field_value = value_acc;
        end
        else
        begin
            r.field_value = {56'd0, b};
        end
        if (cur_field >= KIND_PLEN && cur_field <= KIND_FMT)
            r.entry_number = entry_idx;

        case (cur_field)
            KIND_MAGIC:
            begin
                if (b != MAGIC_LE[{idx[1:0], 3'b000} +: 8])
                    err = ST_BAD_MAGIC;
                if (idx >= 16'd3)
                begin
                    done = 1'b1;
                    nxt = KIND_BLEN;
                end
            end
            KIND_BLEN:
            begin
                if (idx >= 16'd3)
                begin
                    done = 1'b1;
                    body_len = value_acc[31:0];
                    if (body_len < MIN_BODY_FLOOR || body_len < lim_min_body
                        || body_len > lim_max_body)
                        err = ST_BODY_LEN;
                    else
                        nxt = KIND_COUNT;
                end
            end
            KIND_COUNT:
            begin
                if (idx >= 16'd3)
                begin
                    done = 1'b1;
                    n_files = value_acc[31:0];
                    entry_idx = 32'd0;
                    if (n_files < 32'd1 || n_files > lim_max_files)
                        err = ST_COUNT;
                    else if ({1'b0, FIRST_PLEN_END} > stop)
                        err = ST_OVERRUN;
                    else
                        nxt = KIND_PLEN;
                end
            end
            KIND_PLEN:
            begin
                if (idx >= 16'd1)
                begin
                    done = 1'b1;
                    path_len = value_acc[15:0];
                    if (path_len < lim_min_path || path_len > lim_max_path)
                        err = ST_PATH_LEN;
                    else if (pos + 36'd1 + {20'd0, path_len} + {1'b0, FIXED_TAIL} > stop)
                        err = ST_OVERRUN;
                    else
                        nxt = (path_len == 16'd0) ? KIND_OFFSET : KIND_PATH;
                end
            end
            KIND_PATH:
            begin
                if ({1'b0, idx} + 17'd1 >= {1'b0, path_len})
                begin
                    done = 1'b1;
                    nxt = KIND_OFFSET;
                end
            end
            KIND_OFFSET, KIND_SIZE:
            begin
                if (idx >= 16'd7)
                begin
                    done = 1'b1;
                    nxt = (cur_field == KIND_OFFSET) ? KIND_SIZE : KIND_FHASH;
                end
            end
            KIND_FHASH:
            begin
                if (idx >= HASH_LAST_IDX)
                begin
                    done = 1'b1;
                    nxt = KIND_FMT;
                end
            end
            KIND_FMT:
            begin
                if (idx >= 16'd1)
                begin
                    done = 1'b1;
                    entry_idx = entry_idx + 32'd1;
                    if (entry_idx == n_files)
                        nxt = (pos + 36'd1 < stop) ? KIND_SLACK : KIND_MHASH;
                    else if (pos + 36'd3 > stop)
                        err = ST_OVERRUN;
                    else
                        nxt = KIND_PLEN;
                end
            end
            KIND_SLACK:
            begin
                if (pos + 36'd1 >= stop)
                begin
                    done = 1'b1;
                    nxt = KIND_MHASH;
                end
            end
            default:
            begin
                if (idx >= HASH_LAST_IDX)
                begin
                    done = 1'b1;
                    nxt = KIND_BEYOND;
                    fin = 1'b1;
                end
            end
        endcase

        if (done)
        begin
            fld_idx = 16'd0;
            value_acc = 64'd0;
        end
        else
        begin
            fld_idx = fld_idx + 16'd1;
        end

        if (err != ST_OK)
        begin
            sticky_status = err;
            r.status = err;
            fin = 1'b1;
            cur_field = KIND_BEYOND;
        end
        else if (lst && nxt != KIND_BEYOND)
        begin
            sticky_status = ST_TRUNCATED;
            r.status = ST_TRUNCATED;
            fin = 1'b1;
            cur_field = KIND_BEYOND;
        end
        else
        begin
            cur_field = nxt;
        end
        stream_pos = stream_pos + 34'd1;
        r.field_complete = done;
        r.finished = fin;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_MIN_BODY_LEN:   lim_min_body = value;
            CFG_MAX_BODY_LEN:   lim_max_body = value;
            CFG_MAX_FILE_COUNT: lim_max_files = value;
            CFG_MIN_PATH_LEN:   lim_min_path = value[15:0];
            CFG_MAX_PATH_LEN:   lim_max_path = value[15:0];
            default:            ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (manifest_bytes_pending.size() != 0 || in_valid || tags_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic lst);
        manifest_byte_t entry_byte;
        entry_byte.data = b;
        entry_byte.last = lst || (gen_pos == cut_at);
        manifest_bytes_pending.insert(manifest_bytes_pending.size(), entry_byte);
        gen_pos++;
    endtask

    task automatic push_le(input logic [63:0] v, input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            push_byte(v[8 * i +: 8], 1'b0);
    endtask

    task automatic push_entry(input int unsigned e);
        int unsigned i;
        push_le({48'd0, plen_field[e]}, 2);
        for (i = 0; i < path_plan[e]; i++)
            push_byte((e == 0) ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom), 1'b0);
        push_le((e == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom}, 8);
        push_le((e == 0) ? 64'd0 : {$urandom, $urandom}, 8);
        for (i = 0; i < HASH_LEN; i++)
            push_byte(8'($urandom), 1'b0);
        push_le(64'($urandom), 2);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                tags_due.insert(tags_due.size(), tag_manifest_byte(data_byte, last));
                bytes_sent++;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (manifest_bytes_pending.size() != 0)
                begin
                    next_item = manifest_bytes_pending.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= next_item.data;
                    last <= next_item.last;
                    send_gap = (bytes_sent[8:7] == 2'b10) ? 0 : $urandom_range(0, MAX_GAP);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (tags_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                             $time, field_kind, byte_echo);
                    mismatches++;
                end
                else
                begin
                    tag_want = tags_due.pop_front();
                    check_field("field_kind", 64'(tag_want.field_kind), 64'(field_kind));
                    check_field("byte_in_field", 64'(tag_want.byte_in_field),
                                64'(byte_in_field));
                    check_field("entry_number", 64'(tag_want.entry_number), 64'(entry_number));
                    check_field("byte_echo", 64'(tag_want.byte_echo), 64'(byte_echo));
                    check_field("field_value", tag_want.field_value, field_value);
                    check_field("field_complete", 64'(tag_want.field_complete),
                                64'(field_complete));
                    check_field("status", 64'(tag_want.status), 64'(status));
                    check_field("finished", 64'(tag_want.finished), 64'(finished));
                end
                results_seen++;
                if (results_seen == LONG_HOLD_AT)
                    hold_left = LONG_HOLD;
                else if (results_seen[7:6] == 2'b01)
                    hold_left = 0;
                else
                    hold_left = $urandom_range(0, MAX_GAP);
            end
            else if (hold_left != 0)
            begin
                hold_left--;
            end
            out_stall <= (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results still due",
                     $time, quiet_cycles, tags_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        ending_t     ending;
        int unsigned pick;
        int unsigned files;
        int unsigned e;
        int unsigned grp;
        int unsigned i;
        int unsigned need;
        int unsigned slack;
        int unsigned hdr_mode;
        int unsigned cnt_mode;
        logic [31:0] body_bytes;
        longint      manifest_len;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        pick = $urandom_range(0, 9);
        ending = (pick < 5) ? END_COMPLETE : (pick < 7) ? END_TRUNCATED :
                 (pick < 8) ? END_PATH_RANGE : END_OVERRUN;
        files = $urandom_range(20, 28);

        min_p[0] = 16'd1;
        max_p[0] = 16'd4096;
        min_p[1] = 16'd0;
        max_p[1] = 16'($urandom_range(0, 2));
        min_p[2] = 16'($urandom_range(3, 30));
        max_p[2] = min_p[2];
        min_p[3] = 16'($urandom_range(1, 8));
        max_p[3] = 16'hFFFF;

        need = 4;
        for (e = 0; e < files; e++)
        begin
            grp = e * 4 / files;
            case (grp)
                0:       path_plan[e] = (e == 0) ? 1 : $urandom_range(1, 24);
                1:       path_plan[e] = ((e - 1) * 4 / files != grp) ? 0
                                        : $urandom_range(0, max_p[1]);
                2:       path_plan[e] = 32'(max_p[2]);
                default: path_plan[e] = ((e - 1) * 4 / files != grp) ? $urandom_range(200, 400)
                                        : $urandom_range(min_p[3], min_p[3] + 40);
            endcase
            plen_field[e] = path_plan[e][15:0];
            need += ENTRY_FIXED + path_plan[e];
        end
        if (ending == END_PATH_RANGE)
            plen_field[files - 1] = min_p[3] - 16'd1;

        slack = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        if (ending == END_OVERRUN)
        begin
            slack = 0;
            body_bytes = need - $urandom_range(1, 60);
        end
        else
        begin
            body_bytes = need + slack;
        end
        manifest_len = 8 + longint'(body_bytes) + HASH_LEN;
        if (ending == END_TRUNCATED)
            cut_at = $urandom_range(0, 32'(manifest_len - 2));

        hdr_mode = $urandom_range(0, 2);
        cnt_mode = $urandom_range(0, 2);
        if (hdr_mode == 1)
        begin
            write_reg(CFG_MIN_BODY_LEN, 32'd4);
            write_reg(CFG_MAX_BODY_LEN, 32'hFFFF_FFFF);
        end
        else if (hdr_mode == 2)
        begin
            write_reg(CFG_MIN_BODY_LEN, body_bytes);
            write_reg(CFG_MAX_BODY_LEN, body_bytes);
        end
        if (cnt_mode == 1)
            write_reg(CFG_MAX_FILE_COUNT, files);
        else if (cnt_mode == 2)
            write_reg(CFG_MAX_FILE_COUNT, 32'hFFFF_FFFF);

        for (i = 0; i < 4; i++)
            push_byte(MAGIC_LE[8 * i +: 8], 1'b0);
        push_le({32'd0, body_bytes}, 4);
        push_le(64'(files), 4);

        for (e = 0; e < files; e++)
        begin
            grp = e * 4 / files;
            if (e != 0 && (e - 1) * 4 / files != grp)
            begin
                wait_idle();
                write_reg(CFG_MIN_PATH_LEN, (32'($urandom) & 32'hFFFF_0000) | {16'd0, min_p[grp]});
                write_reg(CFG_MAX_PATH_LEN, (32'($urandom) & 32'hFFFF_0000) | {16'd0, max_p[grp]});
            end
            push_entry(e);
        end

        // No limit is consulted once the last entry is through, so the extremes go in here.
        wait_idle();
        write_reg(CFG_MIN_BODY_LEN, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_BODY_LEN, 32'd4);
        write_reg(CFG_MAX_FILE_COUNT, 32'd1);
        write_reg(CFG_MIN_PATH_LEN, (32'($urandom) & 32'hFFFF_0000) | 32'h0000_FFFF);
        write_reg(CFG_MAX_PATH_LEN, 32'($urandom) & 32'hFFFF_0000);

        for (i = 0; i < slack; i++)
            push_byte(8'($urandom), 1'b0);
        for (i = 0; i + 1 < HASH_LEN; i++)
            push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'($urandom_range(0, 1)));
        for (i = 0; i < NOISE_BYTES; i++)
            push_byte(8'($urandom), $urandom_range(0, 3) == 0);

        wait_idle();
        repeat (4) @(posedge clk);

        $display("Streamed %0d bytes: %0d entries, body length %0d, %0d slack bytes, ending %s.",
                 bytes_sent, files, body_bytes, slack, ending.name());
        $display("Compared %0d tagged bytes with %0d field mismatches.", results_seen, mismatches);
        if (mismatches == 0 && tags_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
